// File: design/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared widths, status codes, stage tag types and the arctangent table for
// the two-link arm inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

   localparam int COORD_W    = 16;
   localparam int ANGLE_W    = 17;
   localparam int LINK_W     = 15;
   localparam int GUARD      = 8;
   localparam int ACC_FRAC   = 20;
   localparam int TABLE_LEN  = 24;
   localparam int SQ_W       = 31;
   localparam int SUMSQ_W    = 32;
   localparam int ROOT_IN_W  = 48;
   localparam int ROOT_W     = 24;
   localparam int CORDIC_W   = 28;
   localparam int ACC_W      = 28;
   localparam int SUM_W      = 30;
   localparam int LANES      = 3;

   localparam logic [LINK_W-1:0] LINK_RESET = 15'd3072;

   localparam int DEFAULT_CORDIC_STEPS    = 16;
   localparam int DEFAULT_ANGLE_FRAC_BITS = 7;

   localparam int LANE_ALPHA = 0;
   localparam int LANE_GAMMA = 1;
   localparam int LANE_THETA = 2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_REACH = 2'd1,
      STATUS_DEGEN = 2'd2
   } status_type;

   typedef struct packed {
      status_type                  status;
      logic signed [COORD_W-1:0]   z;
      logic [COORD_W:0]            ax;
      logic signed [COORD_W:0]     sy;
   } root_tag_type;

   // atan(2^-i) in degrees, scaled by 2^ACC_FRAC
   function automatic logic signed [ACC_W-1:0] atan_deg(input int unsigned idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         0:  v = 28'sd47185920;
         1:  v = 28'sd27855475;
         2:  v = 28'sd14718068;
         3:  v = 28'sd7471121;
         4:  v = 28'sd3750058;
         5:  v = 28'sd1876857;
         6:  v = 28'sd938658;
         7:  v = 28'sd469357;
         8:  v = 28'sd234682;
         9:  v = 28'sd117342;
         10: v = 28'sd58671;
         11: v = 28'sd29335;
         12: v = 28'sd14668;
         13: v = 28'sd7334;
         14: v = 28'sd3667;
         15: v = 28'sd1833;
         16: v = 28'sd917;
         17: v = 28'sd458;
         18: v = 28'sd229;
         19: v = 28'sd115;
         20: v = 28'sd57;
         21: v = 28'sd29;
         22: v = 28'sd14;
         23: v = 28'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: design/tlik_sqrt.sv
// ----------------------------------------------------------------------------
// tlik_sqrt
// Three-lane floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tlik_sqrt import tlik_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [ROOT_IN_W-1:0] rad_i [LANES],
   input  root_tag_type         tag_i,
   output logic [ROOT_W-1:0]    root_o [LANES],
   output root_tag_type         tag_o
);

   localparam int REM_W = ROOT_W + 2;

   logic [ROOT_IN_W-1:0] rad_ff [ROOT_W-1][LANES];
   logic [REM_W-1:0]     rem_ff [ROOT_W-1][LANES];
   logic [ROOT_W-1:0]    q_ff   [ROOT_W][LANES];
   root_tag_type         tag_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
         logic [ROOT_IN_W-1:0] rad_prev;
         logic [REM_W-1:0]     rem_prev;
         logic [ROOT_W-1:0]    q_prev;
         logic [REM_W+1:0]     t_rem;
         logic [REM_W+1:0]     trial;
         logic [REM_W+1:0]     diff;
         logic                 ge;
         logic [REM_W-1:0]     rem_in;
         logic [ROOT_W-1:0]    q_in;

         if (k == 0) begin : g_first
            assign rad_prev = rad_i[ln];
            assign rem_prev = '0;
            assign q_prev   = '0;
         end else begin : g_next
            assign rad_prev = rad_ff[k-1][ln];
            assign rem_prev = rem_ff[k-1][ln];
            assign q_prev   = q_ff[k-1][ln];
         end

         always_comb begin
            t_rem = {rem_prev, rad_prev[ROOT_IN_W-1 -: 2]};
            trial = {2'b00, q_prev, 2'b01};
            diff  = t_rem - trial;
            ge    = (t_rem >= trial);
            rem_in = ge ? diff[REM_W-1:0] : t_rem[REM_W-1:0];
            q_in   = {q_prev[ROOT_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               q_ff[k][ln] <= q_in;
            end
         end

         if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (advance) begin
                  rad_ff[k][ln] <= {rad_prev[ROOT_IN_W-3:0], 2'b00};
                  rem_ff[k][ln] <= rem_in;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (k == 0) begin
               tag_ff[k] <= tag_i;
            end else begin
               tag_ff[k] <= tag_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   for (genvar ln = 0; ln < LANES; ln++) begin : g_out
      assign root_o[ln] = q_ff[ROOT_W-1][ln];
   end
   assign tag_o = tag_ff[ROOT_W-1];

endmodule

// File: design/tlik_cordic.sv
// ----------------------------------------------------------------------------
// tlik_cordic
// Three-lane vectoring CORDIC, one micro-rotation per register stage;
// the accumulator holds degrees with ACC_FRAC fraction bits.
// ----------------------------------------------------------------------------
module tlik_cordic import tlik_pkg::*; #(
   parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
) (
   input  logic                       clock,
   input  logic                       advance,
   input  logic signed [CORDIC_W-1:0] x_i [LANES],
   input  logic signed [CORDIC_W-1:0] y_i [LANES],
   input  status_type                 status_i,
   output logic signed [ACC_W-1:0]    acc_o [LANES],
   output status_type                 status_o
);

   logic signed [CORDIC_W-1:0] x_ff   [CORDIC_STEPS-1][LANES];
   logic signed [CORDIC_W-1:0] y_ff   [CORDIC_STEPS-1][LANES];
   logic signed [ACC_W-1:0]    acc_ff [CORDIC_STEPS][LANES];
   status_type                 status_ff [CORDIC_STEPS];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
      for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
         logic signed [CORDIC_W-1:0] x_prev;
         logic signed [CORDIC_W-1:0] y_prev;
         logic signed [ACC_W-1:0]    acc_prev;
         logic signed [CORDIC_W-1:0] dx;
         logic signed [CORDIC_W-1:0] dy;
         logic signed [CORDIC_W-1:0] x_in;
         logic signed [CORDIC_W-1:0] y_in;
         logic signed [ACC_W-1:0]    acc_in;

         if (k == 0) begin : g_first
            assign x_prev   = x_i[ln];
            assign y_prev   = y_i[ln];
            assign acc_prev = '0;
         end else begin : g_next
            assign x_prev   = x_ff[k-1][ln];
            assign y_prev   = y_ff[k-1][ln];
            assign acc_prev = acc_ff[k-1][ln];
         end

         always_comb begin
            dx = y_prev >>> k;
            dy = x_prev >>> k;
            // rotate toward the x axis
            if (!y_prev[CORDIC_W-1]) begin
               x_in   = x_prev + dx;
               y_in   = y_prev - dy;
               acc_in = acc_prev + atan_deg(k);
            end else begin
               x_in   = x_prev - dx;
               y_in   = y_prev + dy;
               acc_in = acc_prev - atan_deg(k);
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               acc_ff[k][ln] <= acc_in;
            end
         end

         if (k < CORDIC_STEPS - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (advance) begin
                  x_ff[k][ln] <= x_in;
                  y_ff[k][ln] <= y_in;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (k == 0) begin
               status_ff[k] <= status_i;
            end else begin
               status_ff[k] <= status_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   for (genvar ln = 0; ln < LANES; ln++) begin : g_out
      assign acc_o[ln] = acc_ff[CORDIC_STEPS-1][ln];
   end
   assign status_o = status_ff[CORDIC_STEPS-1];

endmodule

// File: design/two_link_arm_inverse_kinematics_top.sv
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_top
// Target point in, base/left/right joint angles and a status code out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one target point (x, y, z, signed Q8.8) per word;
//   a word is taken when req_valid is high and req_stall is low.
//   rsp_ channel returns one word per request: three angles in degrees with
//   ANGLE_FRAC_BITS fraction bits and a status (ok, out of reach, degenerate).
//   Angles read zero whenever status is not ok.
//   csr_write_enable loads the link length (unsigned Q7.8) from csr_write_data; write
//   it only while no request is in flight.
// Timing:
//   Throughput is one word per cycle while req_stall is low; the 24-stage
//   square root and the CORDIC_STEPS-stage rotation pipeline set the depth.
//   Reset clears all valid bits and loads a link length of 12.0.
//   When rsp_stall holds a result, one more word drains into a skid
//   register; only then does req_stall rise and the whole pipeline freeze.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics_top import tlik_pkg::*; #(
   parameter int CORDIC_STEPS    = DEFAULT_CORDIC_STEPS,
   parameter int ANGLE_FRAC_BITS = DEFAULT_ANGLE_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_target_x,
   input  logic signed [COORD_W-1:0] req_target_y,
   input  logic signed [COORD_W-1:0] req_target_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ANGLE_W-1:0] rsp_left_angle,
   output logic signed [ANGLE_W-1:0] rsp_right_angle,
   output logic signed [ANGLE_W-1:0] rsp_base_angle,
   output logic [1:0]                rsp_status,
   input  logic                      csr_write_enable,
   input  logic [LINK_W-1:0]         csr_write_data
);

   localparam int N_STAGES = 4 + ROOT_W + CORDIC_STEPS + 2;
   localparam int SHIFT    = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [SUM_W-1:0] DEG90    = SUM_W'(90 * (1 << ACC_FRAC));
   localparam logic signed [SUM_W-1:0] ROUND    = SUM_W'(1 << (SHIFT - 1));
   localparam logic signed [SUM_W-1:0] OUT_MAX  = SUM_W'(65535);
   localparam logic signed [SUM_W-1:0] OUT_MIN  = -SUM_W'(65536);

   function automatic logic signed [ANGLE_W-1:0] to_out(input logic signed [SUM_W-1:0] a);
      logic signed [SUM_W-1:0] v;
      logic signed [ANGLE_W-1:0] r;
      v = (a + ROUND) >>> SHIFT;
      if (v > OUT_MAX) begin
         r = ANGLE_W'(OUT_MAX);
      end else if (v < OUT_MIN) begin
         r = ANGLE_W'(OUT_MIN);
      end else begin
         r = v[ANGLE_W-1:0];
      end
      return r;
   endfunction

   logic [LINK_W-1:0]    link_ff;
   logic [N_STAGES-1:0]  valid_ff;
   logic                 advance;

   // stage 0: captured point
   logic signed [COORD_W-1:0] x0_ff, y0_ff, z0_ff;
   logic [LINK_W-1:0]         l0_ff;
   // stage 1: squares
   logic [SQ_W-1:0]           xx1_ff, yy1_ff, zz1_ff;
   logic [2*LINK_W-1:0]       ll1_ff;
   logic signed [COORD_W-1:0] x1_ff, y1_ff, z1_ff;
   // stage 2: sums
   logic [SUMSQ_W-1:0]        s2_ff, m2_ff, r2_ff;
   logic signed [COORD_W-1:0] x2_ff, y2_ff, z2_ff;
   // stage 3: radicands and status
   logic [ROOT_IN_W-1:0]      rad3_ff [LANES];
   root_tag_type              tag3_ff;
   root_tag_type              tag3_in;
   logic [SUMSQ_W-1:0]        h3;
   logic signed [COORD_W:0]   xs3, ys3;

   logic [ROOT_W-1:0]          root_w [LANES];
   root_tag_type               tag_root;
   logic signed [CORDIC_W-1:0] cx [LANES];
   logic signed [CORDIC_W-1:0] cy [LANES];
   logic signed [ACC_W-1:0]    acc_w [LANES];
   status_type                 status_cordic;

   // combine stage
   logic signed [SUM_W-1:0]   sum_l_ff, sum_r_ff, sum_b_ff;
   status_type                status_c_ff;
   // final stage
   logic signed [ANGLE_W-1:0] fin_l_ff, fin_r_ff, fin_b_ff;
   status_type                fin_status_ff;
   // output register and skid
   logic                      out_valid_ff, skid_valid_ff;
   logic signed [ANGLE_W-1:0] out_l_ff, out_r_ff, out_b_ff;
   logic signed [ANGLE_W-1:0] skid_l_ff, skid_r_ff, skid_b_ff;
   status_type                out_status_ff, skid_status_ff;
   logic                      exiting, out_take;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign exiting   = valid_ff[N_STAGES-1] && advance;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= LINK_RESET;
      end else if (csr_write_enable) begin
         link_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N_STAGES-2:0], req_valid};
      end
   end

   always_comb begin
      h3  = r2_ff - m2_ff;
      xs3 = {x2_ff[COORD_W-1], x2_ff};
      ys3 = {y2_ff[COORD_W-1], y2_ff};
      if (m2_ff > r2_ff) begin
         tag3_in.status = STATUS_REACH;
      end else if (x2_ff == '0 && y2_ff == '0) begin
         tag3_in.status = STATUS_DEGEN;
      end else begin
         tag3_in.status = STATUS_OK;
      end
      tag3_in.z = z2_ff;
      // fold the point into the right half plane
      if (x2_ff[COORD_W-1]) begin
         tag3_in.ax = -xs3;
         tag3_in.sy = -ys3;
      end else begin
         tag3_in.ax = xs3;
         tag3_in.sy = ys3;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff <= req_target_x;
         y0_ff <= req_target_y;
         z0_ff <= req_target_z;
         l0_ff <= link_ff;

         xx1_ff <= SQ_W'(x0_ff * x0_ff);
         yy1_ff <= SQ_W'(y0_ff * y0_ff);
         zz1_ff <= SQ_W'(z0_ff * z0_ff);
         ll1_ff <= l0_ff * l0_ff;
         x1_ff  <= x0_ff;
         y1_ff  <= y0_ff;
         z1_ff  <= z0_ff;

         s2_ff <= SUMSQ_W'(xx1_ff) + SUMSQ_W'(yy1_ff);
         m2_ff <= SUMSQ_W'(xx1_ff) + SUMSQ_W'(yy1_ff) + SUMSQ_W'(zz1_ff);
         r2_ff <= {ll1_ff, 2'b00};
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;

         rad3_ff[LANE_ALPHA] <= {m2_ff, 16'h0000};
         rad3_ff[LANE_GAMMA] <= {s2_ff, 16'h0000};
         rad3_ff[LANE_THETA] <= {h3, 16'h0000};
         tag3_ff <= tag3_in;
      end
   end

   tlik_sqrt u_sqrt (
      .clock   (clock),
      .advance (advance),
      .rad_i   (rad3_ff),
      .tag_i   (tag3_ff),
      .root_o  (root_w),
      .tag_o   (tag_root)
   );

   // root lanes: 0 = m, 1 = s, 2 = h
   always_comb begin
      cx[LANE_ALPHA] = CORDIC_W'(root_w[LANE_ALPHA]);
      cy[LANE_ALPHA] = CORDIC_W'(root_w[LANE_THETA]);
      cx[LANE_GAMMA] = CORDIC_W'(root_w[LANE_GAMMA]);
      cy[LANE_GAMMA] = CORDIC_W'(tag_root.z) <<< GUARD;
      cx[LANE_THETA] = CORDIC_W'(tag_root.ax) << GUARD;
      cy[LANE_THETA] = CORDIC_W'(tag_root.sy) <<< GUARD;
   end

   tlik_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock    (clock),
      .advance  (advance),
      .x_i      (cx),
      .y_i      (cy),
      .status_i (tag_root.status),
      .acc_o    (acc_w),
      .status_o (status_cordic)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_l_ff <= SUM_W'(acc_w[LANE_ALPHA]) + SUM_W'(acc_w[LANE_GAMMA]) - DEG90;
         sum_r_ff <= SUM_W'(acc_w[LANE_ALPHA]) - SUM_W'(acc_w[LANE_GAMMA]);
         sum_b_ff <= DEG90 - SUM_W'(acc_w[LANE_THETA]);
         status_c_ff <= status_cordic;

         fin_status_ff <= status_c_ff;
         if (status_c_ff == STATUS_OK) begin
            fin_l_ff <= to_out(sum_l_ff);
            fin_r_ff <= to_out(sum_r_ff);
            fin_b_ff <= to_out(sum_b_ff);
         end else begin
            fin_l_ff <= '0;
            fin_r_ff <= '0;
            fin_b_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (exiting) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_l_ff      <= skid_l_ff;
            out_r_ff      <= skid_r_ff;
            out_b_ff      <= skid_b_ff;
            out_status_ff <= skid_status_ff;
         end
      end else if (exiting) begin
         if (out_valid_ff && !out_take) begin
            // hold the word in the skid until the receiver drains
            skid_l_ff      <= fin_l_ff;
            skid_r_ff      <= fin_r_ff;
            skid_b_ff      <= fin_b_ff;
            skid_status_ff <= fin_status_ff;
         end else begin
            out_l_ff      <= fin_l_ff;
            out_r_ff      <= fin_r_ff;
            out_b_ff      <= fin_b_ff;
            out_status_ff <= fin_status_ff;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_angle  = out_l_ff;
   assign rsp_right_angle = out_r_ff;
   assign rsp_base_angle  = out_b_ff;
   assign rsp_status      = out_status_ff;

endmodule
